@@ design/q2e_pkg.sv @@
// Shared constants, types and functions for the quaternion to Euler angle block.
// No dependencies; used by the interfaces, the cells and the top level.
package q2e_pkg;

  localparam int QW               = 16;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int STEP_TABLE_LEN   = 24;
  localparam int CORDIC_STEPS     = (ANGLE_ITERATIONS > STEP_TABLE_LEN) ?
                                    STEP_TABLE_LEN : ANGLE_ITERATIONS;
  // radicand is at most 2^56, so 29 root digits cover it
  localparam int SQRT_STEPS = 29;
  localparam int ROOT_W     = 58;
  localparam int VEC_W      = 37;
  localparam int ACC_W      = 34;
  localparam int DEG_W      = 57;
  localparam int LANES      = 3;

  localparam logic signed [ACC_W-1:0] HALF_PI_U30     = 34'sd1686629713;
  localparam logic signed [22:0]      DEG_PER_RAD_Q16 = 23'sd3754936;

  localparam logic [1:0] CFG_UNITS = 2'd0;
  localparam logic [1:0] CFG_AXIS  = 2'd1;

  localparam logic [1:0] CTRL_SRC_ROLL  = 2'd0;
  localparam logic [1:0] CTRL_SRC_PITCH = 2'd1;
  localparam logic [1:0] CTRL_SRC_YAW   = 2'd2;

  localparam int LANE_YAW   = 0;
  localparam int LANE_ROLL  = 1;
  localparam int LANE_PITCH = 2;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ACC_W-1:0] acc;
    logic                    zero;
  } vec_t;

  // atan(2^-i) in units of 2^-30 rad
  function automatic logic signed [ACC_W-1:0] step_angle(input logic [4:0] i);
    logic signed [ACC_W-1:0] r;
    case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [QW-1:0] sat16(input logic signed [17:0] v);
    logic signed [QW-1:0] r;
    if (v > 18'sd32767) r = 16'sh7fff;
    else if (v < -18'sd32768) r = 16'sh8000;
    else r = v[QW-1:0];
    return r;
  endfunction

endpackage

@@ design/q2e_quat_if.sv @@
// Input channel: one quaternion item with valid/ready handshake.
// Depends on q2e_pkg.
interface q2e_quat_if import q2e_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] quat_w;
  logic signed [QW-1:0] quat_x;
  logic signed [QW-1:0] quat_y;
  logic signed [QW-1:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

@@ design/q2e_euler_if.sv @@
// Output channel: one set of Euler angles with valid/ready handshake.
// Depends on q2e_pkg.
interface q2e_euler_if import q2e_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] yaw_angle;
  logic signed [QW-1:0] pitch_angle;
  logic signed [QW-1:0] roll_angle;
  logic signed [QW-1:0] control_angle;
  logic                 pitch_clamped;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, control_angle,
                  pitch_clamped, input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, control_angle,
                  pitch_clamped, output ready);
endinterface

@@ design/q2e_sqrt_cell.sv @@
// One digit of the restoring integer square root, registered.
// Depends on q2e_pkg.
module q2e_sqrt_cell import q2e_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [4:0]        digit_i,
  input  logic [ROOT_W-1:0] rem_i,
  input  logic [ROOT_W-1:0] root_i,
  output logic [ROOT_W-1:0] rem_o,
  output logic [ROOT_W-1:0] root_o
);
  logic [ROOT_W-1:0] bit_w, trial, rem_d, root_d, rem_q, root_q;

  always_comb begin
    bit_w = ROOT_W'(1) << {digit_i, 1'b0};
    trial = root_i + bit_w;
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + bit_w;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
endmodule

@@ design/q2e_cordic_cell.sv @@
// One vectoring CORDIC step for all three angle lanes, registered.
// Depends on q2e_pkg.
module q2e_cordic_cell import q2e_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [4:0]            step_i,
  input  vec_t [LANES-1:0]      vec_i,
  output vec_t [LANES-1:0]      vec_o
);
  vec_t [LANES-1:0] vec_d, vec_q;
  logic signed [ACC_W-1:0] ang;

  always_comb begin
    ang = step_angle(step_i);
    for (int k = 0; k < LANES; k++) begin
      vec_d[k].zero = vec_i[k].zero;
      if (!vec_i[k].y[VEC_W-1]) begin
        vec_d[k].x   = vec_i[k].x + (vec_i[k].y >>> step_i);
        vec_d[k].y   = vec_i[k].y - (vec_i[k].x >>> step_i);
        vec_d[k].acc = vec_i[k].acc + ang;
      end else begin
        vec_d[k].x   = vec_i[k].x - (vec_i[k].y >>> step_i);
        vec_d[k].y   = vec_i[k].y + (vec_i[k].x >>> step_i);
        vec_d[k].acc = vec_i[k].acc - ang;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;
endmodule

@@ design/quaternion_to_euler_unit.sv @@
// Top level: quaternion in, ZYX Euler angles out, fully pipelined.
// Depends on q2e_pkg, q2e_quat_if, q2e_euler_if, q2e_sqrt_cell, q2e_cordic_cell.
//
// Usage:
//   quat  : sink channel, one unit quaternion item (w, x, y, z) in signed Q1.14.
//   euler : source channel, yaw, pitch, roll, a control copy of one angle and
//           a flag that the arcsine argument was clamped.
//   cfg   : write port, index 0 selects units (radians Q2.13 / degrees Q8.7),
//           index 1 selects the control axis (0 roll, 1 pitch, 2 yaw).
//   There are 6 + 29 + 16 = 51 register stages: products, sums, square,
//   29 square-root digit cells, pre-rotation, 16 CORDIC cells, unit multiply
//   and the output register.
//   Throughput is one item per cycle unless the receiver stalls; every stage
//   is a register, and all three angles share the CORDIC cells side by side.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and quat.ready drops; it rises again in the cycle the result is taken.
//   Reset clears all valid bits and sets units to radians, axis to pitch.
//   Configuration changes apply to items entering the output register.
module quaternion_to_euler_unit import q2e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  q2e_quat_if.sink   quat,
  q2e_euler_if.source euler,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [1:0] cfg_data_i
);
  localparam int ST_SQ   = 2;
  localparam int ST_ROT  = 3 + SQRT_STEPS;
  localparam int ST_CONV = ST_ROT + CORDIC_STEPS + 1;
  localparam int NST     = ST_CONV + 2;

  typedef struct packed {
    logic signed [VEC_W-1:0] yaw_y;
    logic signed [VEC_W-1:0] yaw_x;
    logic signed [VEC_W-1:0] roll_y;
    logic signed [VEC_W-1:0] roll_x;
    logic signed [29:0]      s;
  } side_t;

  logic             units_q;
  logic [1:0]       axis_q;
  logic [NST-1:0]   vld_q;
  logic [NST-1:1]   cl_q;
  logic             adv;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      units_q <= 1'b0;
      axis_q  <= CTRL_SRC_PITCH;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_UNITS) units_q <= cfg_data_i[0];
      else if (cfg_idx_i == CFG_AXIS) axis_q <= cfg_data_i;
    end
  end

  assign adv        = !vld_q[NST-1] || euler.ready;
  assign quat.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], quat.valid};
    end
  end

  // stage A: products
  logic signed [31:0] wz_q, xy_q, yy_q, zz_q, wx_q, yz_q, xx_q, wy_q, zx_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      wz_q <= quat.quat_w * quat.quat_z;
      xy_q <= quat.quat_x * quat.quat_y;
      yy_q <= quat.quat_y * quat.quat_y;
      zz_q <= quat.quat_z * quat.quat_z;
      wx_q <= quat.quat_w * quat.quat_x;
      yz_q <= quat.quat_y * quat.quat_z;
      xx_q <= quat.quat_x * quat.quat_x;
      wy_q <= quat.quat_w * quat.quat_y;
      zx_q <= quat.quat_z * quat.quat_x;
    end
  end

  // stage B: sums and clamp
  localparam logic signed [VEC_W-1:0] ONE_V = VEC_W'(64'sd1 <<< 28);
  logic signed [34:0] s_full;
  logic signed [29:0] s_d;
  logic               clamp_d;
  side_t              b_q;

  always_comb begin
    s_full = (35'(wy_q) - 35'(zx_q)) <<< 1;
    clamp_d = 1'b0;
    s_d = s_full[29:0];
    if (s_full > 35'sd268435456) begin
      s_d = 30'sd268435456;
      clamp_d = 1'b1;
    end else if (s_full < -35'sd268435456) begin
      s_d = -30'sd268435456;
      clamp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_q.yaw_y  <= (VEC_W'(wz_q) + VEC_W'(xy_q)) <<< 1;
      b_q.yaw_x  <= ONE_V - ((VEC_W'(yy_q) + VEC_W'(zz_q)) <<< 1);
      b_q.roll_y <= (VEC_W'(wx_q) + VEC_W'(yz_q)) <<< 1;
      b_q.roll_x <= ONE_V - ((VEC_W'(xx_q) + VEC_W'(yy_q)) <<< 1);
      b_q.s      <= s_d;
    end
  end

  // clamp flag rides along; its last stage is the output flag
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cl_q <= {cl_q[NST-2:1], clamp_d};
    end
  end

  // stage C: square of the pitch sine
  logic signed [59:0] sq_full;
  logic [56:0]        sq_q;
  side_t              side_q [0:SQRT_STEPS];

  assign sq_full = b_q.s * b_q.s;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q      <= sq_full[56:0];
      side_q[0] <= b_q;
      for (int k = 1; k <= SQRT_STEPS; k++) side_q[k] <= side_q[k-1];
    end
  end

  // square root chain: c = floor(sqrt(2^56 - s^2))
  logic [ROOT_W-1:0] rem_w  [0:SQRT_STEPS];
  logic [ROOT_W-1:0] root_w [0:SQRT_STEPS];
  assign rem_w[0]  = (ROOT_W'(1) << 56) - ROOT_W'(sq_q);
  assign root_w[0] = '0;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .digit_i (5'(SQRT_STEPS - 1 - g)),
      .rem_i   (rem_w[g]),
      .root_i  (root_w[g]),
      .rem_o   (rem_w[g+1]),
      .root_o  (root_w[g+1])
    );
  end

  // pre-rotation into the right half plane
  function automatic vec_t prerot(input logic signed [VEC_W-1:0] y,
                                  input logic signed [VEC_W-1:0] x);
    vec_t r;
    r.zero = (x == '0) && (y == '0);
    r.x    = x;
    r.y    = y;
    r.acc  = '0;
    if (x[VEC_W-1]) begin
      if (!y[VEC_W-1]) begin
        r.x   = y;
        r.y   = -x;
        r.acc = HALF_PI_U30;
      end else begin
        r.x   = -y;
        r.y   = x;
        r.acc = -HALF_PI_U30;
      end
    end
    return r;
  endfunction

  vec_t [LANES-1:0] vec_w [0:CORDIC_STEPS];
  side_t            sd;
  assign sd = side_q[SQRT_STEPS];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vec_w[0][LANE_YAW]   <= prerot(sd.yaw_y, sd.yaw_x);
      vec_w[0][LANE_ROLL]  <= prerot(sd.roll_y, sd.roll_x);
      vec_w[0][LANE_PITCH] <= prerot(VEC_W'(sd.s), VEC_W'(root_w[SQRT_STEPS]));
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    q2e_cordic_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .step_i (5'(g)),
      .vec_i  (vec_w[g]),
      .vec_o  (vec_w[g+1])
    );
  end

  // unit conversion multiply
  logic signed [ACC_W-1:0] ang_q [LANES];
  logic signed [DEG_W-1:0] deg_q [LANES];
  logic signed [ACC_W-1:0] ang_d [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      ang_d[k] = vec_w[CORDIC_STEPS][k].zero ? '0 : vec_w[CORDIC_STEPS][k].acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < LANES; k++) begin
        ang_q[k] <= ang_d[k];
        deg_q[k] <= DEG_W'(ang_d[k]) * DEG_W'(DEG_PER_RAD_Q16);
      end
    end
  end

  // rounding, saturation, output register
  logic signed [QW-1:0]    res   [LANES];
  logic signed [ACC_W-1:0] rad_t [LANES];
  logic signed [DEG_W-1:0] deg_t [LANES];
  logic signed [QW-1:0]    ctl_d;
  logic signed [QW-1:0]    yaw_q, pitch_q, roll_q, ctl_q;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      rad_t[k] = ang_q[k] + (ACC_W'(1) <<< 16);
      deg_t[k] = deg_q[k] + (DEG_W'(1) <<< 38);
      if (units_q) res[k] = sat16(deg_t[k][DEG_W-1:39]);
      else         res[k] = sat16(18'(signed'(rad_t[k][ACC_W-1:17])));
    end
    case (axis_q)
      CTRL_SRC_ROLL:  ctl_d = res[LANE_ROLL];
      CTRL_SRC_PITCH: ctl_d = res[LANE_PITCH];
      CTRL_SRC_YAW:   ctl_d = res[LANE_YAW];
      default:        ctl_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yaw_q   <= res[LANE_YAW];
      pitch_q <= res[LANE_PITCH];
      roll_q  <= res[LANE_ROLL];
      ctl_q   <= ctl_d;
    end
  end

  assign euler.valid         = vld_q[NST-1];
  assign euler.yaw_angle     = yaw_q;
  assign euler.pitch_angle   = pitch_q;
  assign euler.roll_angle    = roll_q;
  assign euler.control_angle = ctl_q;
  assign euler.pitch_clamped = cl_q[NST-1];

  // the clamped sine sits exactly on plus or minus one
  a_clamp_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && cl_q[1] |->
      (b_q.s == 30'sd268435456 || b_q.s == -30'sd268435456))
    else $error("clamp flag without saturated sine");

  // root never exceeds one in Q.28
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_ROT-1] |-> root_w[SQRT_STEPS] <= (ROOT_W'(1) << 28))
    else $error("square root out of range");

  // after pre-rotation every vector lies in the right half plane
  a_right_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_ROT] |-> (!vec_w[0][LANE_YAW].x[VEC_W-1] &&
                       !vec_w[0][LANE_ROLL].x[VEC_W-1] &&
                       !vec_w[0][LANE_PITCH].x[VEC_W-1]))
    else $error("pre-rotation left a negative x");

  // an item in the square stage moves on into the first root stage when the pipeline advances
  a_sq_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld_q[ST_SQ] |=> vld_q[ST_SQ+1])
    else $error("item lost entering square root");

endmodule

@@ tb/sv/tb_quaternion_to_euler_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for quaternion_to_euler_unit: quaternion items in,
// predicted ZYX angles compared item by item. Needs q2e_pkg and both channel interfaces.
module tb_quaternion_to_euler_unit;
  import q2e_pkg::*;

  localparam int LAT_WAIT  = 70;
  localparam int WDOG_MAX  = 3000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] ctrl;
    logic               clamped;
  } angles_t;

  class euler_scoreboard;
    angles_t   pending_q[$];
    bit        deg_mode;
    bit [1:0]  axis_sel;
    int        errors;
    int        checked;
    int        clamps;
    longint    atan_tab[24];

    function void init();
      atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                   16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                   131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
      deg_mode = 1'b0;
      axis_sel = CTRL_SRC_PITCH;
      errors   = 0;
      checked  = 0;
      clamps   = 0;
    endfunction

    function longint vec_angle(longint y, longint x);
      longint acc, t, xs, ys;
      int n;
      acc = 0;
      if (x == 0 && y == 0) return 0;
      // left half plane: pre-rotate by a quarter turn
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; acc = 1686629713;
        end else begin
          x = -y; y = t; acc = -1686629713;
        end
      end
      n = (ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS;
      for (int i = 0; i < n; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; acc += atan_tab[i];
        end else begin
          x -= ys; y += xs; acc -= atan_tab[i];
        end
      end
      return acc;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function logic signed [15:0] scale_angle(longint a);
      longint r;
      if (deg_mode) r = (a * 64'sd3754936 + (64'sd1 <<< 38)) >>> 39;
      else r = (a + (64'sd1 <<< 16)) >>> 17;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function void note_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                            logic signed [15:0] qy, logic signed [15:0] qz);
      longint w, x, y, z, s, one;
      angles_t e;
      w = qw; x = qx; y = qy; z = qz;
      one = 64'sd1 <<< 28;
      e.clamped = 1'b0;
      e.yaw  = scale_angle(vec_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z)));
      e.roll = scale_angle(vec_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y)));
      s = 2 * (w * y - z * x);
      if (s > one) begin s = one; e.clamped = 1'b1; end
      if (s < -one) begin s = -one; e.clamped = 1'b1; end
      e.pitch = scale_angle(vec_angle(s, longint'(int_sqrt((64'd1 << 56) -
                                                           longint'(s * s)))));
      case (axis_sel)
        CTRL_SRC_ROLL:  e.ctrl = e.roll;
        CTRL_SRC_PITCH: e.ctrl = e.pitch;
        CTRL_SRC_YAW:   e.ctrl = e.yaw;
        default:        e.ctrl = '0;
      endcase
      if (e.clamped) clamps++;
      pending_q.push_back(e);
    endfunction

    function void check_angles(angles_t got);
      angles_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: result with no item pending: %p", $realtime, got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (got.yaw != e.yaw) begin
        $display("%0t: yaw exp %0d got %0d", $realtime, e.yaw, got.yaw); errors++;
      end
      if (got.pitch != e.pitch) begin
        $display("%0t: pitch exp %0d got %0d", $realtime, e.pitch, got.pitch); errors++;
      end
      if (got.roll != e.roll) begin
        $display("%0t: roll exp %0d got %0d", $realtime, e.roll, got.roll); errors++;
      end
      if (got.ctrl != e.ctrl) begin
        $display("%0t: control exp %0d got %0d", $realtime, e.ctrl, got.ctrl); errors++;
      end
      if (got.clamped != e.clamped) begin
        $display("%0t: clamp exp %0b got %0b", $realtime, e.clamped, got.clamped);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [1:0] cfg_data_i;

  q2e_quat_if  quat_ch ();
  q2e_euler_if euler_ch ();

  quaternion_to_euler_unit u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .quat      (quat_ch.sink),
    .euler     (euler_ch.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  euler_scoreboard sb;
  bit no_idle;
  bit hold_req;
  int sent;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    sb = new();
    sb.init();
  end

  // accept monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (quat_ch.valid && quat_ch.ready)
        sb.note_quat(quat_ch.quat_w, quat_ch.quat_x, quat_ch.quat_y, quat_ch.quat_z);
      if (euler_ch.valid && euler_ch.ready)
        sb.check_angles('{euler_ch.yaw_angle, euler_ch.pitch_angle, euler_ch.roll_angle,
                          euler_ch.control_angle, euler_ch.pitch_clamped});
      if ((quat_ch.valid && quat_ch.ready) || (euler_ch.valid && euler_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("%0t: watchdog expired, %0d results pending", $realtime,
                 sb.pending_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int n;
    euler_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 11);
      if (hold_req) begin
        n = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (n > 0) begin
        euler_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      euler_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!euler_ch.valid) @(posedge clk_i);
    end
  end

  task automatic send_quat(int w, int x, int y, int z);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      quat_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    quat_ch.valid  <= 1'b1;
    quat_ch.quat_w <= 16'(w);
    quat_ch.quat_x <= 16'(x);
    quat_ch.quat_y <= 16'(y);
    quat_ch.quat_z <= 16'(z);
    @(posedge clk_i);
    while (!quat_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  // stop offering, then wait for every pending result plus pipeline drain
  task automatic drain();
    quat_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LAT_WAIT) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_UNITS) sb.deg_mode = val[0];
    else if (idx == CFG_AXIS) sb.axis_sel = val;
    @(posedge clk_i);
  endtask

  // random unit quaternion, sometimes pushed toward gimbal lock
  task automatic send_unit_quat();
    real a[4];
    real nrm;
    int  q[4];
    do begin
      for (int i = 0; i < 4; i++) a[i] = $itor($urandom_range(0, 32768)) - 16384.0;
      if ($urandom_range(0, 7) == 0) begin
        a[2] = a[0] * (($urandom_range(0, 1) != 0) ? 1.0 : -1.0);
        a[1] = a[1] / 64.0;
        a[3] = a[3] / 64.0;
      end
      nrm = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
    end while (nrm < 100.0);
    for (int i = 0; i < 4; i++) q[i] = $rtoi(a[i] * 16384.0 / nrm);
    send_quat(q[0], q[1], q[2], q[3]);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    quat_ch.valid = 1'b0;
    quat_ch.quat_w = '0;
    quat_ch.quat_x = '0;
    quat_ch.quat_y = '0;
    quat_ch.quat_z = '0;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    sent        = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items at reset settings
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 0, 0, -16384);
    send_quat(11586, 0, 11586, 0);     // just past +90 pitch, clamps
    send_quat(11586, 0, -11586, 0);    // just past -90 pitch
    send_quat(11585, 0, 11585, 0);     // just inside
    send_quat(0, 0, 0, 0);             // all-zero quaternion
    send_quat(8192, 8192, 8192, 8192);
    send_quat(-8192, 8192, -8192, 8192);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(-32768, 32767, 32767, -32768);
    send_quat(0, 16384, 16384, 0);
    send_quat(16384, 16384, -16384, 16384);
    drain();
    write_cfg(CFG_UNITS, 2'd1);
    write_cfg(CFG_AXIS, 2'd3);         // unused selector gives zero
    send_quat(11586, 0, 11586, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(-16384, 0, 0, 0);
    drain();

    // random phases over every setting
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(CFG_UNITS, {1'b0, ph[0]});
      write_cfg(CFG_AXIS, ph[2:1]);
      no_idle = (ph == 3 || ph == 6);
      if (ph == 1) hold_req = 1'b1;
      for (int k = 0; k < 75; k++) begin
        if (ph == 5 && k == 40) begin
          quat_ch.valid <= 1'b0;
          while (sb.pending_q.size() != 0) @(posedge clk_i);
        end
        if ($urandom_range(0, 9) < 8) send_unit_quat();
        else send_quat($urandom, $urandom, $urandom, $urandom);
      end
      drain();
    end

    $display("Sent %0d quaternions, checked %0d angle sets (%0d clamped pitch)",
             sent, sb.checked, sb.clamps);
    $display("All unit/axis settings visited, including the unused axis selector");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
